/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the rtl modules
// every use expects signals named clk and rst in the enclosing module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BVM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bvm_pkg.sv */
// ----------------------------------------------------------------------------
// bvm_pkg
// shared widths, register codes, constants and control structs of the
// battery voltage monitor
// ----------------------------------------------------------------------------
package bvm_pkg;

  // adc sample width actually used out of the raw field
  localparam int SAMPLE_BITS = 12;
  localparam int RAW_W       = 12;

  // apb port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EMPTY  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FULL   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CHARGE = 3'd5;

  // datapath widths
  localparam int OFFSET_W = 12;
  localparam int GAIN_W   = 23;
  localparam int VOLT_W   = 16;
  localparam int MV_W     = 21;   // signed smoothed value
  localparam int OUT_MV_W = 20;
  localparam int PCT_W    = 7;
  localparam int Q10_W    = 19;
  localparam int NUM_W    = 24;
  localparam int DIV_STEPS = 7;
  localparam int STEP_W    = 3;

  localparam logic [MV_W-1:0] MV_MAX = 21'h0F_FFFF;
  localparam logic [MV_W-1:0] MV_MIN = 21'h10_0000;

  // floor(x / 10) = (x * RECIP_10) >> RECIP_SHIFT, exact for x below 2^22
  localparam logic [26:0] RECIP_10    = 27'd107374183;
  localparam int          RECIP_SHIFT = 30;

  localparam int PCT_X2 = 200;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef struct packed {
    logic                enable;
    logic [OFFSET_W-1:0] count_offset;
    logic [GAIN_W-1:0]   gain_q16;
    logic [VOLT_W-1:0]   empty_mv;
    logic [VOLT_W-1:0]   full_mv;
    logic [VOLT_W-1:0]   charge_mv;
  } bvm_cfg_t;

  typedef struct packed {
    logic              take;
    logic              conv;
    logic              smooth;
    logic              update;
    logic              prep;
    logic              div_step;
    logic [STEP_W-1:0] div_idx;
    logic              out_load;
  } bvm_cmd_t;

  typedef struct packed {
    logic s_pos;
    logic out_free;
  } bvm_sts_t;

endpackage

/* hw/rtl/bvm_if.sv */
// ----------------------------------------------------------------------------
// bvm_if
// valid/ready channels of the battery voltage monitor: samples in, results out
// ----------------------------------------------------------------------------
interface bvm_sample_if;
  logic                     valid;
  logic                     ready;
  logic [bvm_pkg::RAW_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface bvm_result_if;
  logic                         valid;
  logic                         ready;
  logic [bvm_pkg::OUT_MV_W-1:0] millivolts;
  logic                         percent_valid;
  logic [bvm_pkg::PCT_W-1:0]    percent;
  logic                         charge_valid;
  logic                         charging;

  modport source (
    output valid, output millivolts, output percent_valid, output percent,
    output charge_valid, output charging, input ready
  );
  modport sink (
    input valid, input millivolts, input percent_valid, input percent,
    input charge_valid, input charging, output ready
  );
endinterface

/* hw/rtl/bvm_regs.sv */
// ----------------------------------------------------------------------------
// bvm_regs
// apb configuration registers of the battery voltage monitor
// ----------------------------------------------------------------------------
module bvm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bvm_pkg::PADDR_W-1:0]   paddr,
  input  logic [bvm_pkg::PDATA_W-1:0]   pwdata,
  output logic [bvm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output bvm_pkg::bvm_cfg_t             cfg
);

  logic                              wr_en;
  logic [bvm_pkg::REG_IDX_W-1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[bvm_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        bvm_pkg::REG_ENABLE: cfg.enable       <= pwdata[0];
        bvm_pkg::REG_OFFSET: cfg.count_offset <= pwdata[bvm_pkg::OFFSET_W-1:0];
        bvm_pkg::REG_GAIN:   cfg.gain_q16     <= pwdata[bvm_pkg::GAIN_W-1:0];
        bvm_pkg::REG_EMPTY:  cfg.empty_mv     <= pwdata[bvm_pkg::VOLT_W-1:0];
        bvm_pkg::REG_FULL:   cfg.full_mv      <= pwdata[bvm_pkg::VOLT_W-1:0];
        bvm_pkg::REG_CHARGE: cfg.charge_mv    <= pwdata[bvm_pkg::VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bvm_pkg::REG_ENABLE: prdata = bvm_pkg::PDATA_W'(cfg.enable);
      bvm_pkg::REG_OFFSET: prdata = bvm_pkg::PDATA_W'(cfg.count_offset);
      bvm_pkg::REG_GAIN:   prdata = bvm_pkg::PDATA_W'(cfg.gain_q16);
      bvm_pkg::REG_EMPTY:  prdata = bvm_pkg::PDATA_W'(cfg.empty_mv);
      bvm_pkg::REG_FULL:   prdata = bvm_pkg::PDATA_W'(cfg.full_mv);
      bvm_pkg::REG_CHARGE: prdata = bvm_pkg::PDATA_W'(cfg.charge_mv);
      default:             prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/bvm_ctrl.sv */
// ----------------------------------------------------------------------------
// bvm_ctrl
// sequencer of the battery voltage monitor: walks one sample through
// conversion, smoothing, percent division and the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bvm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              enable,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  bvm_pkg::bvm_sts_t sts,
  output bvm_pkg::bvm_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam logic [bvm_pkg::STEP_W-1:0] DIV_FIRST =
    bvm_pkg::STEP_W'(bvm_pkg::DIV_STEPS - 1);
  localparam logic [bvm_pkg::STEP_W-1:0] DIV_LAST = '0;

  logic [2:0]                   state, state_next;
  logic [bvm_pkg::STEP_W-1:0]   step, step_next;

  assign sample_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.take = 1'b1;
          // disabled: item is dropped, smoothed value untouched
          if (enable) state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv   = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.smooth = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        if (sts.s_pos) begin
          cmd.prep   = 1'b1;
          step_next  = DIV_FIRST;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_idx  = step;
        if (step == DIV_LAST) state_next = ST_DONE;
        else step_next = step - 1'b1;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  `BVM_ASSERT_NEXT(a_div_exit, state == ST_DIV && step == DIV_LAST, state == ST_DONE, "divider did not hand over to result stage")
  `BVM_ASSERT_IMPL(a_load_free, cmd.out_load, sts.out_free, "result register overwritten while full")
  `BVM_ASSERT_NEXT(a_nopos_idle, state == ST_PREP && !sts.s_pos, state == ST_IDLE, "result produced for nonpositive voltage")

endmodule

/* hw/rtl/bvm_dpath.sv */
// ----------------------------------------------------------------------------
// bvm_dpath
// datapath of the battery voltage monitor: scaling multiply, rounding,
// smoothing by reciprocal multiply, serial percent divider, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bvm_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  bvm_pkg::bvm_cfg_t           cfg,
  input  logic [bvm_pkg::RAW_W-1:0]   raw_sample,
  input  bvm_pkg::bvm_cmd_t           cmd,
  output bvm_pkg::bvm_sts_t           sts,
  bvm_result_if.source                result
);

  // conversion
  logic [bvm_pkg::SAMPLE_BITS-1:0] raw_lo;
  logic signed [13:0]              sum_c;
  logic signed [23:0]              gain_s;
  logic signed [37:0]              prod;
  logic [36:0]                     mag_c;
  logic [36:0]                     rsum_c;
  logic [20:0]                     qc;
  logic [bvm_pkg::MV_W-1:0]        mv_c, mv;

  // smoothing
  logic [bvm_pkg::MV_W-1:0]        smoothed;
  logic [21:0]                     d_c, dmag_c, a_c;
  logic [48:0]                     rp_c;
  logic [bvm_pkg::Q10_W-1:0]       q10;
  logic                            dneg, load_direct;
  logic [bvm_pkg::MV_W-1:0]        step_c;

  // percent
  logic                            pv_c, ge_full_c, le_empty_c;
  logic [bvm_pkg::VOLT_W-1:0]      span_c, sd_c;
  logic                            pv, ge_full, le_empty;
  logic [bvm_pkg::NUM_W-1:0]       rem;
  logic [16:0]                     dvs;
  logic [bvm_pkg::NUM_W-1:0]       dsh_c;
  logic [bvm_pkg::PCT_W-1:0]       quo, pct_c;

  // result register
  logic                            ovld;
  logic [bvm_pkg::OUT_MV_W-1:0]    omv;
  logic                            opv, ocv, ochg;
  logic [bvm_pkg::PCT_W-1:0]       opct;

  // signed offset + unsigned gain, product registered on acceptance
  assign raw_lo = raw_sample[bvm_pkg::SAMPLE_BITS-1:0];
  assign sum_c  = $signed(14'(raw_lo)) +
                  $signed({{2{cfg.count_offset[bvm_pkg::OFFSET_W-1]}}, cfg.count_offset});
  assign gain_s = $signed({1'b0, cfg.gain_q16});

  always_ff @(posedge clk) begin
    if (cmd.take) prod <= sum_c * gain_s;
  end

  // round half away from zero, then saturate to 21-bit signed
  assign mag_c  = prod[37] ? 37'(-prod) : prod[36:0];
  assign rsum_c = mag_c + 37'd32768;
  assign qc     = rsum_c[36:16];

  always_comb begin
    if (!prod[37]) mv_c = qc[20] ? bvm_pkg::MV_MAX : qc;
    else if (qc > 21'd1048576) mv_c = bvm_pkg::MV_MIN;
    else mv_c = ~qc + 21'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.conv) mv <= mv_c;
  end

  // round((mv - s) / 10) = sign * floor((|mv - s| + 5) / 10)
  assign d_c    = {mv[20], mv} - {smoothed[20], smoothed};
  assign dmag_c = d_c[21] ? (~d_c + 22'd1) : d_c;
  assign a_c    = dmag_c + 22'd5;
  assign rp_c   = 49'(a_c) * 49'(bvm_pkg::RECIP_10);

  always_ff @(posedge clk) begin
    if (cmd.smooth) begin
      q10         <= rp_c[48:bvm_pkg::RECIP_SHIFT];
      dneg        <= d_c[21];
      load_direct <= (smoothed == '0);
    end
  end

  assign step_c = dneg ? (~{2'b00, q10} + 21'd1) : {2'b00, q10};

  always_ff @(posedge clk) begin
    if (rst) smoothed <= '0;
    else if (cmd.update) smoothed <= load_direct ? mv : smoothed + step_c;
  end

  assign sts.s_pos = !smoothed[20] && (smoothed != '0);

  // percent setup, only reached with a positive smoothed value
  assign pv_c       = (cfg.empty_mv != '0) && (cfg.full_mv > cfg.empty_mv);
  assign ge_full_c  = smoothed >= bvm_pkg::MV_W'(cfg.full_mv);
  assign le_empty_c = smoothed <= bvm_pkg::MV_W'(cfg.empty_mv);
  assign span_c     = cfg.full_mv - cfg.empty_mv;
  assign sd_c       = smoothed[bvm_pkg::VOLT_W-1:0] - cfg.empty_mv;

  // quotient floor((200*(s-empty) + span) / (2*span)) stays below 101 when
  // empty < s < full, so seven restoring steps suffice
  assign dsh_c = bvm_pkg::NUM_W'(dvs) << cmd.div_idx;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      pv       <= pv_c;
      ge_full  <= ge_full_c;
      le_empty <= le_empty_c;
      rem      <= bvm_pkg::NUM_W'(sd_c) * bvm_pkg::NUM_W'(bvm_pkg::PCT_X2) +
                  bvm_pkg::NUM_W'(span_c);
      dvs      <= {span_c, 1'b0};
      quo      <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dsh_c) begin
        rem          <= rem - dsh_c;
        quo[cmd.div_idx] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (!pv || le_empty) pct_c = '0;
    else if (ge_full) pct_c = bvm_pkg::PCT_FULL;
    else pct_c = quo;
  end

  // result register: a finished item waits here while the next is taken
  always_ff @(posedge clk) begin
    if (rst) ovld <= 1'b0;
    else if (cmd.out_load) ovld <= 1'b1;
    else if (result.ready) ovld <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      omv  <= smoothed[bvm_pkg::OUT_MV_W-1:0];
      opv  <= pv;
      opct <= pct_c;
      ocv  <= (cfg.charge_mv != '0);
      ochg <= (cfg.charge_mv != '0) && (smoothed >= bvm_pkg::MV_W'(cfg.charge_mv));
    end
  end

  assign sts.out_free = !ovld || result.ready;

  assign result.valid         = ovld;
  assign result.millivolts    = omv;
  assign result.percent_valid = opv;
  assign result.percent       = opct;
  assign result.charge_valid  = ocv;
  assign result.charging      = ochg;

  `BVM_ASSERT_IMPL(a_pct_range, ovld, opct <= bvm_pkg::PCT_FULL, "percent above full scale")
  `BVM_ASSERT_IMPL(a_pct_zero, ovld && !opv, opct == '0, "percent set while invalid")
  `BVM_ASSERT_NEXT(a_s_hold, !cmd.update, $stable(smoothed), "smoothed value moved outside update")

endmodule

/* hw/rtl/battery_voltage_monitor_unit.sv */
// flow: an accepted sample passes convert, diff, update, prep, the 7-step
//   percent divider and the result load; one without a result returns to idle
//   from prep, one taken while disabled is dropped; the single shared sequencer
//   takes samples only in idle; a waiting result does not block the next sample
// reset: synchronous, clears registers, smoothed value, sequencer and result valid
// ----------------------------------------------------------------------------
// battery_voltage_monitor_unit
// adc battery gauge: scales raw samples to millivolts, smooths them, and
// reports voltage, state of charge and a charging flag
// ----------------------------------------------------------------------------
module battery_voltage_monitor_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bvm_pkg::PADDR_W-1:0]   paddr,
  input  logic [bvm_pkg::PDATA_W-1:0]   pwdata,
  output logic [bvm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // item channels
  bvm_sample_if.sink                    sample,
  bvm_result_if.source                  result
);

  // register map: enable, count_offset, gain_q16, empty_mv, full_mv,
  // charge_mv at word addresses 0..5; writes are expected only while idle
  bvm_pkg::bvm_cfg_t cfg;
  bvm_pkg::bvm_cmd_t cmd;
  bvm_pkg::bvm_sts_t sts;

  bvm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: idle -> convert -> diff -> update -> prep -> 7 divide steps
  // -> result load; items are taken only in idle
  bvm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .enable       (cfg.enable),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // datapath: the scaling product is captured in the accept cycle, so the
  // raw sample is only needed while the item is handed over
  bvm_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .raw_sample (sample.raw_sample),
    .cmd        (cmd),
    .sts        (sts),
    .result     (result)
  );

endmodule
